>>> design/dq_pkg.sv
package dq_pkg;

  localparam int unsigned DEPTH    = 16;
  localparam int unsigned IDX_W    = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W    = $clog2(DEPTH + 1);
  localparam int unsigned WORD_W   = 32;
  localparam int unsigned OCC_W    = 5;
  localparam int unsigned CODE_W   = 3;
  localparam int unsigned OTDATA_W = 40;

  typedef enum logic [CODE_W-1:0] {
    ACT_PUSH_FRONT = 3'd0,
    ACT_PUSH_REAR  = 3'd1,
    ACT_POP_FRONT  = 3'd2,
    ACT_POP_REAR   = 3'd3,
    ACT_LIST       = 3'd4
  } action_e;

  typedef enum logic [CODE_W-1:0] {
    ST_PUSHED = 3'd0,
    ST_POPPED = 3'd1,
    ST_UNDER  = 3'd2,
    ST_OVER   = 3'd3,
    ST_LISTED = 3'd4,
    ST_EMPTY  = 3'd5
  } status_e;

  typedef enum logic [2:0] {
    OP_NONE,
    OP_PUSH_FRONT,
    OP_PUSH_REAR,
    OP_POP_FRONT,
    OP_POP_REAR,
    OP_LIST_START,
    OP_LIST_RD,
    OP_LIST_NEXT
  } dp_op_e;

  typedef enum logic [1:0] {
    SRC_ZERO,
    SRC_IN,
    SRC_MEM
  } out_src_e;

  typedef enum logic [1:0] {
    S_IDLE,
    S_POP,
    S_LIST_RD,
    S_LIST_WR
  } state_e;

  typedef struct packed {
    dp_op_e   op;
    logic     out_load;
    status_e  out_status;
    out_src_e out_src;
    logic     out_last;
  } dq_cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
    logic list_last;
    logic out_free;
  } dq_stat_t;

  // Circular index addition; both operands are below DEPTH.
  function automatic logic [IDX_W-1:0] wrap_add(logic [IDX_W-1:0] base,
                                                logic [IDX_W-1:0] off);
    logic [IDX_W:0] sum;
    sum = {1'b0, base} + {1'b0, off};
    if (sum >= (IDX_W+1)'(DEPTH)) begin
      sum = sum - (IDX_W+1)'(DEPTH);
    end
    return sum[IDX_W-1:0];
  endfunction

endpackage

>>> design/dq_ctrl.sv
module dq_ctrl (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic [2:0]         in_action_i,
  output logic               in_ready_o,
  input  dq_pkg::dq_stat_t   stat_i,
  output dq_pkg::dq_cmd_t    cmd_o
);
  import dq_pkg::*;

  state_e state_q, state_d;
  logic   accept;

  assign in_ready_o = (state_q == S_IDLE) && stat_i.out_free;
  assign accept     = in_valid_i && in_ready_o;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d = state_q;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_e'(in_action_i))
            ACT_POP_FRONT, ACT_POP_REAR: begin
              if (!stat_i.empty) state_d = S_POP;
            end
            ACT_LIST: begin
              if (!stat_i.empty) state_d = S_LIST_RD;
            end
            default: state_d = S_IDLE;
          endcase
        end
      end
      S_POP: begin
        if (stat_i.out_free) state_d = S_IDLE;
      end
      S_LIST_RD: state_d = S_LIST_WR;
      S_LIST_WR: begin
        if (stat_i.out_free) begin
          state_d = stat_i.list_last ? S_IDLE : S_LIST_RD;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    cmd_o            = '0;
    cmd_o.op         = OP_NONE;
    cmd_o.out_status = ST_PUSHED;
    cmd_o.out_src    = SRC_ZERO;
    case (state_q)
      S_IDLE: begin
        if (accept) begin
          case (action_e'(in_action_i))
            ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
              cmd_o.out_load = 1'b1;
              cmd_o.out_last = 1'b1;
              if (stat_i.full) begin
                cmd_o.out_status = ST_OVER;
              end else begin
                cmd_o.op = (action_e'(in_action_i) == ACT_PUSH_FRONT) ?
                           OP_PUSH_FRONT : OP_PUSH_REAR;
                cmd_o.out_status = ST_PUSHED;
                cmd_o.out_src    = SRC_IN;
              end
            end
            ACT_POP_FRONT, ACT_POP_REAR: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = ST_UNDER;
              end else begin
                cmd_o.op = (action_e'(in_action_i) == ACT_POP_FRONT) ?
                           OP_POP_FRONT : OP_POP_REAR;
              end
            end
            ACT_LIST: begin
              if (stat_i.empty) begin
                cmd_o.out_load   = 1'b1;
                cmd_o.out_last   = 1'b1;
                cmd_o.out_status = ST_EMPTY;
              end else begin
                cmd_o.op = OP_LIST_START;
              end
            end
            default: cmd_o.op = OP_NONE;
          endcase
        end
      end
      S_POP: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_last   = 1'b1;
          cmd_o.out_status = ST_POPPED;
          cmd_o.out_src    = SRC_MEM;
        end
      end
      S_LIST_RD: cmd_o.op = OP_LIST_RD;
      S_LIST_WR: begin
        if (stat_i.out_free) begin
          cmd_o.out_load   = 1'b1;
          cmd_o.out_last   = stat_i.list_last;
          cmd_o.out_status = ST_LISTED;
          cmd_o.out_src    = SRC_MEM;
          if (!stat_i.list_last) cmd_o.op = OP_LIST_NEXT;
        end
      end
      default: cmd_o.op = OP_NONE;
    endcase
  end

endmodule

>>> design/dq_datapath.sv
module dq_datapath (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic [dq_pkg::WORD_W-1:0]    in_value_i,
  input  dq_pkg::dq_cmd_t              cmd_i,
  output dq_pkg::dq_stat_t             stat_o,
  output logic                         out_valid_o,
  input  logic                         out_ready_i,
  output logic [dq_pkg::CODE_W-1:0]    out_status_o,
  output logic [dq_pkg::WORD_W-1:0]    out_value_o,
  output logic [dq_pkg::OCC_W-1:0]     out_occ_o,
  output logic                         out_last_o
);
  import dq_pkg::*;

  logic [WORD_W-1:0] mem [DEPTH];

  logic [IDX_W-1:0]  head_q, head_d;
  logic [CNT_W-1:0]  cnt_q, cnt_d;
  logic [IDX_W-1:0]  idx_q, idx_d;
  logic [WORD_W-1:0] rd_data_q;

  logic              we, re;
  logic [IDX_W-1:0]  waddr, raddr;

  logic              out_valid_q;
  status_e           out_status_q;
  logic [WORD_W-1:0] out_value_q;
  logic [OCC_W-1:0]  out_occ_q;
  logic              out_last_q;
  logic [WORD_W-1:0] out_value_d;

  assign stat_o.full      = (cnt_q == CNT_W'(DEPTH));
  assign stat_o.empty     = (cnt_q == '0);
  assign stat_o.list_last = ((CNT_W'(idx_q) + CNT_W'(1)) == cnt_q);
  assign stat_o.out_free  = !out_valid_q || out_ready_i;

  always_comb begin
    head_d = head_q;
    cnt_d  = cnt_q;
    idx_d  = idx_q;
    we     = 1'b0;
    re     = 1'b0;
    waddr  = wrap_add(head_q, IDX_W'(cnt_q));
    raddr  = head_q;
    case (cmd_i.op)
      OP_PUSH_FRONT: begin
        head_d = wrap_add(head_q, IDX_W'(DEPTH - 1));
        waddr  = head_d;
        we     = 1'b1;
        cnt_d  = cnt_q + CNT_W'(1);
      end
      OP_PUSH_REAR: begin
        we    = 1'b1;
        cnt_d = cnt_q + CNT_W'(1);
      end
      OP_POP_FRONT: begin
        re     = 1'b1;
        head_d = wrap_add(head_q, IDX_W'(1));
        cnt_d  = cnt_q - CNT_W'(1);
      end
      OP_POP_REAR: begin
        re    = 1'b1;
        raddr = wrap_add(head_q, IDX_W'(cnt_q - CNT_W'(1)));
        cnt_d = cnt_q - CNT_W'(1);
      end
      OP_LIST_START: idx_d = '0;
      OP_LIST_RD: begin
        re    = 1'b1;
        raddr = wrap_add(head_q, idx_q);
      end
      OP_LIST_NEXT: idx_d = idx_q + IDX_W'(1);
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      head_q      <= '0;
      cnt_q       <= '0;
      idx_q       <= '0;
      out_valid_q <= 1'b0;
    end else begin
      head_q <= head_d;
      cnt_q  <= cnt_d;
      idx_q  <= idx_d;
      if (cmd_i.out_load) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // The read data register only moves on a read, so it holds across stalls.
  always_ff @(posedge clk_i) begin
    if (we) mem[waddr] <= in_value_i;
    if (re) rd_data_q <= mem[raddr];
  end

  always_comb begin
    case (cmd_i.out_src)
      SRC_IN:  out_value_d = in_value_i;
      SRC_MEM: out_value_d = rd_data_q;
      default: out_value_d = '0;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_load) begin
      out_status_q <= cmd_i.out_status;
      out_value_q  <= out_value_d;
      out_occ_q    <= OCC_W'(cnt_d);
      out_last_q   <= cmd_i.out_last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign out_status_o = out_status_q;
  assign out_value_o  = out_value_q;
  assign out_occ_o    = out_occ_q;
  assign out_last_o   = out_last_q;

endmodule

>>> design/double_ended_queue_top.sv
// Bounded double-ended queue of signed 32-bit words, 16 entries deep.
// Input stream: each word carries an action in tuser (push front, push rear,
// pop front, pop rear, list) and, for pushes, the word to store in tdata.
// Output stream: tuser carries the status, tdata the popped, listed or echoed
// word (zero on an error status) with the occupancy above it, and tlast marks
// the final result of an action.
// A push, or any action on a full or empty queue that only reports status,
// has its result in the output register in the cycle after it is taken;
// pushes can follow each other every cycle while the receiver keeps up.
// A pop reads the store through a registered port, then in the pop state
// loads the read word into the output register. A list clears its index,
// then per held word reads the store in the list read state and loads the
// output register in the list write state; the next action is taken after its last result.
// Actions with an unknown code are taken and dropped without a result.
// Reset empties the queue and clears the output valid flag; the store itself
// is not cleared and needs no sweep.
// When the receiver stalls, the result holds in the output register and the
// block stops taking input until that register can be refilled.
module double_ended_queue_top (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           s_axis_tvalid_i,
  output logic                           s_axis_tready_o,
  input  logic [dq_pkg::WORD_W-1:0]      s_axis_tdata_i,  // [31:0] value
  input  logic [dq_pkg::CODE_W-1:0]      s_axis_tuser_i,  // [2:0] action
  output logic                           m_axis_tvalid_o,
  input  logic                           m_axis_tready_i,
  output logic [dq_pkg::OTDATA_W-1:0]    m_axis_tdata_o,  // [31:0] value_res, [36:32] occupancy
  output logic [dq_pkg::CODE_W-1:0]      m_axis_tuser_o,  // [2:0] status
  output logic                           m_axis_tlast_o
);
  import dq_pkg::*;

  dq_cmd_t           cmd;
  dq_stat_t          stat;
  logic [WORD_W-1:0] out_value;
  logic [OCC_W-1:0]  out_occ;

  dq_ctrl u_ctrl (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (s_axis_tvalid_i),
    .in_action_i (s_axis_tuser_i),
    .in_ready_o  (s_axis_tready_o),
    .stat_i      (stat),
    .cmd_o       (cmd)
  );

  dq_datapath u_datapath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .in_value_i   (s_axis_tdata_i),
    .cmd_i        (cmd),
    .stat_o       (stat),
    .out_valid_o  (m_axis_tvalid_o),
    .out_ready_i  (m_axis_tready_i),
    .out_status_o (m_axis_tuser_o),
    .out_value_o  (out_value),
    .out_occ_o    (out_occ),
    .out_last_o   (m_axis_tlast_o)
  );

  assign m_axis_tdata_o = {(OTDATA_W - WORD_W - OCC_W)'(0), out_occ, out_value};

  // A new word is taken only when the output register can accept a result.
  a_ready_needs_room: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tready_o |-> (!m_axis_tvalid_o || m_axis_tready_i))
    else $error("input taken while output register is blocked");

  a_occ_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid_o |-> (out_occ <= OCC_W'(DEPTH)))
    else $error("occupancy above depth");

  a_error_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && (m_axis_tuser_o == ST_UNDER || m_axis_tuser_o == ST_OVER
                         || m_axis_tuser_o == ST_EMPTY))
    |-> (out_value == '0))
    else $error("error status with nonzero word");

  a_over_full: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (m_axis_tvalid_o && m_axis_tuser_o == ST_OVER) |-> (out_occ == OCC_W'(DEPTH)))
    else $error("overflow reported on a queue that is not full");

endmodule

>>> sim/dq_checker.sv
module dq_checker (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        s_tvalid_i,
  input  logic                        s_tready_i,
  input  logic [dq_pkg::WORD_W-1:0]   s_tdata_i,
  input  logic [dq_pkg::CODE_W-1:0]   s_tuser_i,
  input  logic                        m_tvalid_i,
  input  logic                        m_tready_i,
  input  logic [dq_pkg::OTDATA_W-1:0] m_tdata_i,
  input  logic [dq_pkg::CODE_W-1:0]   m_tuser_i,
  input  logic                        m_tlast_i,
  output int                          fail_count_o,
  output int                          due_count_o
);
  import dq_pkg::*;

  typedef struct packed {
    status_e             status;
    logic [WORD_W-1:0]   word;
    logic [OCC_W-1:0]    occ;
    logic                last;
  } dq_result_t;

  // Shadow of the queue contents, kept as a circular store like the block.
  logic [WORD_W-1:0] dq_words [DEPTH];
  int unsigned       dq_head;
  int unsigned       dq_count;

  dq_result_t        due_results [$];
  int                fails;

  assign fail_count_o = fails;

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    $display("mismatch at %0t: %s got %0h, expected %0h", $realtime, what, got, want);
    fails++;
  endtask

  task automatic expect_result(status_e st, logic [WORD_W-1:0] word, logic last);
    dq_result_t r;
    r.status = st;
    r.word   = word;
    r.occ    = OCC_W'(dq_count);
    r.last   = last;
    due_results.push_back(r);
  endtask

  // Applies one accepted action to the shadow queue and queues its results.
  task automatic step_deque(logic [CODE_W-1:0] code, logic [WORD_W-1:0] word);
    logic [WORD_W-1:0] taken;
    case (code)
      ACT_PUSH_FRONT, ACT_PUSH_REAR: begin
        if (dq_count >= DEPTH) begin
          expect_result(ST_OVER, '0, 1'b1);
        end else begin
          if (code == ACT_PUSH_FRONT) begin
            dq_head = (dq_head + DEPTH - 1) % DEPTH;
            dq_words[dq_head] = word;
          end else begin
            dq_words[(dq_head + dq_count) % DEPTH] = word;
          end
          dq_count++;
          expect_result(ST_PUSHED, word, 1'b1);
        end
      end
      ACT_POP_FRONT, ACT_POP_REAR: begin
        if (dq_count == 0) begin
          expect_result(ST_UNDER, '0, 1'b1);
        end else begin
          if (code == ACT_POP_FRONT) begin
            taken = dq_words[dq_head];
            dq_head = (dq_head + 1) % DEPTH;
          end else begin
            taken = dq_words[(dq_head + dq_count - 1) % DEPTH];
          end
          dq_count--;
          expect_result(ST_POPPED, taken, 1'b1);
        end
      end
      ACT_LIST: begin
        if (dq_count == 0) begin
          expect_result(ST_EMPTY, '0, 1'b1);
        end else begin
          for (int unsigned i = 0; i < dq_count; i++) begin
            expect_result(ST_LISTED, dq_words[(dq_head + i) % DEPTH], i + 1 == dq_count);
          end
        end
      end
      default: ;
    endcase
  endtask

  task automatic check_result();
    dq_result_t want;
    if (due_results.size() == 0) begin
      report_mismatch("result with nothing due, tdata", 64'(m_tdata_i), '0);
      return;
    end
    want = due_results.pop_front();
    if (m_tuser_i !== want.status) begin
      report_mismatch("status", 64'(m_tuser_i), 64'(want.status));
    end
    if (m_tdata_i[WORD_W-1:0] !== want.word) begin
      report_mismatch("value", 64'(m_tdata_i[WORD_W-1:0]), 64'(want.word));
    end
    // The occupancy sits above the value; the padding bits must stay zero.
    if (m_tdata_i[OTDATA_W-1:WORD_W] !== (OTDATA_W - WORD_W)'(want.occ)) begin
      report_mismatch("occupancy", 64'(m_tdata_i[OTDATA_W-1:WORD_W]), 64'(want.occ));
    end
    if (m_tlast_i !== want.last) begin
      report_mismatch("last", 64'(m_tlast_i), 64'(want.last));
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      dq_head  = 0;
      dq_count = 0;
      fails    = 0;
      due_results.delete();
      due_count_o = 0;
    end else begin
      if (s_tvalid_i && s_tready_i) begin
        step_deque(s_tuser_i, s_tdata_i);
      end
      if (m_tvalid_i && m_tready_i) begin
        check_result();
      end
      due_count_o = due_results.size();
    end
  end

endmodule

>>> sim/tb.sv
module tb;
  import dq_pkg::*;

  localparam int CYCLE_LIMIT  = 600000;
  localparam int RANDOM_ITEMS = 350;
  localparam int MAX_GAP      = 13;

  logic                clk_i;
  logic                rst_ni   = 1'b0;
  logic                s_tvalid = 1'b0;
  logic                s_tready;
  logic [WORD_W-1:0]   s_tdata  = '0;
  logic [CODE_W-1:0]   s_tuser  = '0;
  logic                m_tvalid;
  logic                m_tready = 1'b0;
  logic [OTDATA_W-1:0] m_tdata;
  logic [CODE_W-1:0]   m_tuser;
  logic                m_tlast;

  int fail_count;
  int due_count;
  int cycle_count = 0;
  int sent_items  = 0;
  bit tx_calm     = 1'b0;

  double_ended_queue_top u_top (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .s_axis_tvalid_i (s_tvalid),
    .s_axis_tready_o (s_tready),
    .s_axis_tdata_i  (s_tdata),
    .s_axis_tuser_i  (s_tuser),
    .m_axis_tvalid_o (m_tvalid),
    .m_axis_tready_i (m_tready),
    .m_axis_tdata_o  (m_tdata),
    .m_axis_tuser_o  (m_tuser),
    .m_axis_tlast_o  (m_tlast)
  );

  dq_checker u_checker (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_tvalid_i   (s_tvalid),
    .s_tready_i   (s_tready),
    .s_tdata_i    (s_tdata),
    .s_tuser_i    (s_tuser),
    .m_tvalid_i   (m_tvalid),
    .m_tready_i   (m_tready),
    .m_tdata_i    (m_tdata),
    .m_tuser_i    (m_tuser),
    .m_tlast_i    (m_tlast),
    .fail_count_o (fail_count),
    .due_count_o  (due_count)
  );

  initial begin
    clk_i = 1'b0;
    forever #5 clk_i = ~clk_i;
  end

  initial begin
    repeat (12) @(negedge clk_i);
    rst_ni <= 1'b1;
  end

  always @(posedge clk_i) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("tb NOT OK");
      $finish;
    end
  end

  // Extremes of the word range come up often; the rest is uniform.
  function automatic logic [WORD_W-1:0] pick_word();
    case ($urandom_range(0, 7))
      0:       return 32'h8000_0000;
      1:       return 32'h7fff_ffff;
      2:       return '0;
      3:       return '1;
      default: return $urandom();
    endcase
  endfunction

  // Called at a falling edge; returns at the falling edge after the word is taken.
  task automatic send_word(logic [CODE_W-1:0] code, logic [WORD_W-1:0] word);
    int gap;
    gap = tx_calm ? 0 : $urandom_range(0, MAX_GAP);
    if (gap > 0) begin
      s_tvalid <= 1'b0;
      repeat (gap) @(negedge clk_i);
    end
    s_tvalid <= 1'b1;
    s_tuser  <= code;
    s_tdata  <= word;
    @(posedge clk_i);
    while (!s_tready) @(posedge clk_i);
    @(negedge clk_i);
    if (code <= ACT_LIST) begin
      sent_items++;
    end
  endtask

  task automatic fill_run();
    int n;
    n = $urandom_range(DEPTH + 1, DEPTH + 4);
    repeat (n) begin
      send_word($urandom_range(0, 1) ? ACT_PUSH_FRONT : ACT_PUSH_REAR, pick_word());
    end
    send_word(ACT_LIST, pick_word());
  endtask

  task automatic drain_run();
    int n;
    n = $urandom_range(DEPTH + 1, DEPTH + 4);
    repeat (n) begin
      send_word($urandom_range(0, 1) ? ACT_POP_FRONT : ACT_POP_REAR, pick_word());
    end
    send_word(ACT_LIST, pick_word());
  endtask

  task automatic mixed_run();
    int n;
    int r;
    n = $urandom_range(8, 30);
    repeat (n) begin
      r = $urandom_range(0, 99);
      if (r < 23) begin
        send_word(ACT_PUSH_FRONT, pick_word());
      end else if (r < 46) begin
        send_word(ACT_PUSH_REAR, pick_word());
      end else if (r < 64) begin
        send_word(ACT_POP_FRONT, pick_word());
      end else if (r < 82) begin
        send_word(ACT_POP_REAR, pick_word());
      end else if (r < 94) begin
        send_word(ACT_LIST, pick_word());
      end else begin
        send_word(CODE_W'($urandom_range(int'(ACT_LIST) + 1, 2**CODE_W - 1)), pick_word());
      end
    end
  endtask

  // Receiver: stalls a random number of cycles before each word, with calm stretches.
  initial begin
    int gap;
    int taken;
    taken = 0;
    @(posedge rst_ni);
    @(negedge clk_i);
    forever begin
      if (taken % 30 == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? -1 : 0;
      end
      if (gap < 0 || $urandom_range(0, 1)) begin
        gap = (gap < 0) ? -1 : 0;
      end
      if (gap == 0) begin
        gap = $urandom_range(0, MAX_GAP);
        if (gap > 0) begin
          m_tready <= 1'b0;
          repeat (gap) @(negedge clk_i);
        end
        gap = 0;
      end
      m_tready <= 1'b1;
      @(posedge clk_i);
      while (!m_tvalid) @(posedge clk_i);
      @(negedge clk_i);
      taken++;
    end
  end

  initial begin
    int target;
    @(posedge rst_ni);
    @(negedge clk_i);

    // Empty queue: list, both pops, and every unused action code.
    send_word(ACT_LIST, pick_word());
    send_word(ACT_POP_FRONT, '1);
    send_word(ACT_POP_REAR, '1);
    for (int c = int'(ACT_LIST) + 1; c < 2**CODE_W; c++) begin
      send_word(CODE_W'(c), pick_word());
    end
    // Extreme words at both ends; the front push wraps the head index.
    send_word(ACT_PUSH_FRONT, 32'h8000_0000);
    send_word(ACT_PUSH_REAR, 32'h7fff_ffff);
    send_word(ACT_PUSH_FRONT, '1);
    send_word(ACT_LIST, '0);
    send_word(ACT_POP_REAR, '0);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_POP_FRONT, '0);
    send_word(ACT_LIST, '1);
    send_word(ACT_PUSH_REAR, '0);
    send_word(ACT_POP_REAR, '1);

    // Fill to overflow and drain to underflow first, then random runs.
    target = sent_items + RANDOM_ITEMS;
    fill_run();
    drain_run();
    while (sent_items < target) begin
      tx_calm = ($urandom_range(0, 3) == 0);
      case ($urandom_range(0, 3))
        0:       fill_run();
        1:       drain_run();
        default: mixed_run();
      endcase
    end
    tx_calm = 1'b0;
    s_tvalid <= 1'b0;

    while (due_count != 0) @(posedge clk_i);
    repeat (50) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("tb OK");
    end else begin
      $display("tb NOT OK");
    end
    $finish;
  end

endmodule
